FILE: rtl/spq_pkg.sv
// spq_pkg: shared types and codes of the sorted priority queue.
// No dependencies; used by spq_cell, spq_obuf and sorted_priority_queue.
package spq_pkg;

  // request codes
  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_CLR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef struct packed {
    logic [DataW-1:0]        value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [DataW-1:0]        value;
    logic signed [DataW-1:0] prio;
    logic [CountW-1:0]       count;
  } result_t;

endpackage

FILE: rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain, holding a single entry.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_greater_i,
  input  spq_pkg::entry_t    right_i,
  output spq_pkg::entry_t    entry_o,
  output logic               greater_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // new item ranks ahead of this slot (empty slots always lose)
  assign greater_o = !valid_i || ($signed(new_i.prio) > $signed(entry_q.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (greater_o) begin
        entry_d = left_greater_i ? left_i : new_i;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/spq_obuf.sv
// spq_obuf: output register plus skid slot for result items.
// Depends on spq_pkg.
module spq_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spq_pkg::result_t res_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output spq_pkg::result_t res_o
);
  import spq_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_free) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level, a chain of DEPTH sorting cells with
// an occupancy counter and a two-slot output buffer.
// Depends on spq_pkg, spq_cell and spq_obuf.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  request | in        | in_valid_i / in_stall_o| req_type, item_value, item_priority
//  result  | out       | out_valid_o/out_stall_i| status, out_value, out_priority,
//          |           |                        | entry_count
//
// One item per cycle while in_stall_o is low: every cell compares the new
// priority in parallel and the affected cells shift at the accepting edge;
// the result is registered in the output buffer.
// Reset clears the occupancy count and empties the output buffer; cell
// contents are not reset, slots at or above the count are never read.
// A stalled result holds the output register and the next result waits in a
// skid slot; the request side stalls only while that slot is occupied.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] item_value_i,
  input  logic signed [31:0] item_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] out_value_o,
  output logic signed [31:0] out_priority_o,
  output logic [4:0]  entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          in_accept;
  logic          full, empty;
  cell_ctrl_t    ctrl;
  entry_t        new_entry;
  entry_t        cell_entry [DEPTH];
  logic          cell_greater [DEPTH];
  result_t       res;
  result_t       res_out;
  logic          obuf_full;
  logic [CW+CountW-1:0] count_ext;

  assign in_stall_o = obuf_full;
  assign in_accept  = in_valid_i && !obuf_full;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign new_entry.value = item_value_i;
  assign new_entry.prio  = item_priority_i;

  // broadcast command: only accepted, non-rejected requests move the chain
  assign ctrl.enq = in_accept && (req_type_i == REQ_ENQ) && !full;
  assign ctrl.deq = in_accept && (req_type_i == REQ_DEQ) && !empty;

  // cell chain; slot 0 is the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .valid_i        (CW'(g) < count_q),
      .new_i          (new_entry),
      .left_i         ((g == 0) ? new_entry : cell_entry[(g == 0) ? 0 : g-1]),
      .left_greater_i ((g == 0) ? 1'b0 : cell_greater[(g == 0) ? 0 : g-1]),
      .right_i        ((g == DEPTH-1) ? cell_entry[g]
                                      : cell_entry[(g == DEPTH-1) ? g : g+1]),
      .entry_o        (cell_entry[g]),
      .greater_o      (cell_greater[g])
    );
  end

  // next count and result item
  always_comb begin
    count_d    = count_q;
    res.status = ST_OK;
    res.value  = '0;
    res.prio   = '0;
    unique case (req_type_i)
      REQ_ENQ: begin
        if (full) res.status = ST_FULL;
        else      count_d    = count_q + CW'(1);
      end
      REQ_DEQ: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = cell_entry[0].value;
          res.prio  = cell_entry[0].prio;
          count_d   = count_q - CW'(1);
        end
      end
      REQ_CLR: count_d = '0;
      default: ;  // unused code: no change
    endcase
    count_ext = {{CountW{1'b0}}, count_d};
    res.count = count_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_accept) begin
      count_q <= count_d;
    end
  end

  spq_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .res_i       (res),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign status_o       = res_out.status;
  assign out_value_o    = res_out.value;
  assign out_priority_o = res_out.prio;
  assign entry_count_o  = res_out.count;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid slot held while output register empty");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not advance count");

  a_clr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && req_type_i == REQ_CLR) |=> count_q == '0)
    else $error("clear left entries behind");

  a_ctrl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.enq && ctrl.deq))
    else $error("enqueue and dequeue together");

endmodule

FILE: bench/tb_sorted_priority_queue.sv
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue.
// Needs spq_pkg and sorted_priority_queue; a directed table, then shaped random
// traffic, each result checked against its pinned table value or an in-bench queue predictor.
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TotalItems = 1550;
  localparam int unsigned CalmTail   = 150;   // last items run with no gaps or stalls
  localparam int unsigned PrintLimit = 40;

  // request code with no function; the block must leave the queue alone
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_e;

  // one line of the directed table; want is only used when pinned is set
  typedef struct packed {
    logic [1:0]         req;
    logic [31:0]        val;
    logic signed [31:0] prio;
    int unsigned        reps;     // repeated with val stepping by one
    bit                 pinned;
    result_t            want;
  } dir_row_t;

  // per-item note from the sender, taken by the monitor at acceptance
  typedef struct packed {
    bit      pinned;
    result_t want;
  } item_note_t;

  localparam dir_row_t DirectedRows [14] = '{
    // dequeue straight after reset: empty
    '{REQ_DEQ,  32'h0,        32'sh0,        1,  1'b1, '{ST_EMPTY, 32'h0, 32'sh0, 5'd0}},
    // unused code and clear on an empty queue
    '{REQ_NONE, 32'h0,        32'sh0,        1,  1'b1, '{ST_OK,    32'h0, 32'sh0, 5'd0}},
    '{REQ_CLR,  32'h0,        32'sh0,        1,  1'b1, '{ST_OK,    32'h0, 32'sh0, 5'd0}},
    // extremes of value and priority
    '{REQ_ENQ,  32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1, 1'b1, '{ST_OK,   32'h0, 32'sh0, 5'd1}},
    '{REQ_ENQ,  32'h0,        32'sh8000_0000, 1,  1'b1, '{ST_OK,    32'h0, 32'sh0, 5'd2}},
    '{REQ_ENQ,  32'h5A5A_5A5A, 32'sh0,       1,  1'b1, '{ST_OK,    32'h0, 32'sh0, 5'd3}},
    '{REQ_ENQ,  32'hA5A5_A5A5, 32'shFFFF_FFFF, 1, 1'b1, '{ST_OK,   32'h0, 32'sh0, 5'd4}},
    // twelve ties on priority zero fill the queue; order among equals matters
    '{REQ_ENQ,  32'h0000_0100, 32'sh0,       12, 1'b0, '0},
    // enqueue on a full queue is refused
    '{REQ_ENQ,  32'h1234_5678, 32'sh1,       1,  1'b1, '{ST_FULL,  32'h0, 32'sh0, 5'd16}},
    // head is the top priority entry
    '{REQ_DEQ,  32'h0,        32'sh0,        1,  1'b1,
      '{ST_OK, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 5'd15}},
    '{REQ_DEQ,  32'h0,        32'sh0,        2,  1'b0, '0},
    '{REQ_NONE, 32'hDEAD_BEEF, 32'sh55,      1,  1'b0, '0},
    '{REQ_CLR,  32'h0,        32'sh0,        1,  1'b1, '{ST_OK,    32'h0, 32'sh0, 5'd0}},
    '{REQ_DEQ,  32'h0,        32'sh0,        1,  1'b1, '{ST_EMPTY, 32'h0, 32'sh0, 5'd0}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         req_type_i;
  logic [31:0]        item_value_i;
  logic signed [31:0] item_priority_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         status_o;
  logic [31:0]        out_value_o;
  logic signed [31:0] out_priority_o;
  logic [4:0]         entry_count_o;

  // predictor state: entries kept sorted, head first
  entry_t      queue_entries[$];
  result_t     pending_results[$];
  item_note_t  item_notes[$];
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_count = 0;
  bit          idle_on       = 1'b1;   // shared gap/stall switch for both sides

  sorted_priority_queue #(
    .DEPTH(QueueDepth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .entry_count_o  (entry_count_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one request to the sorted copy and returns what the block must say.
  // A new entry lands after every entry of equal or higher priority, so ties
  // keep arrival order.
  function automatic result_t apply_request(input logic [1:0] req, input logic [31:0] val,
                                            input logic signed [31:0] prio);
    result_t     res;
    entry_t      fresh;
    int unsigned slot;
    res = '0;
    res.status = ST_OK;
    case (req)
      REQ_ENQ: begin
        if (queue_entries.size() >= QueueDepth) begin
          res.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < queue_entries.size() && !(prio > queue_entries[slot].prio)) slot++;
          fresh.value = val;
          fresh.prio  = prio;
          queue_entries.insert(slot, fresh);
        end
      end
      REQ_DEQ: begin
        if (queue_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = queue_entries[0].value;
          res.prio  = queue_entries[0].prio;
          void'(queue_entries.pop_front());
        end
      end
      REQ_CLR: begin
        queue_entries.delete();
      end
      default: ;   // unused code: no change
    endcase
    res.count = CountW'(queue_entries.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PrintLimit)
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Monitor. Everything is sampled at the rising edge, before the edge's own
  // updates land, so stimulus driven at this edge is not yet visible.
  // Acceptance is logged first so a same-edge result would still find its match.
  always @(posedge clk_i) begin
    item_note_t note;
    result_t    predicted;
    result_t    want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        note = item_notes.pop_front();
        predicted = apply_request(req_type_i, item_value_i, item_priority_i);
        // a pinned row still goes through the predictor to keep its state in step
        pending_results.push_back(note.pinned ? note.want : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(status_o), 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 32'(status_o), 32'(want.status));
          if (out_value_o !== want.value)
            report_mismatch("value", out_value_o, want.value);
          if (out_priority_o !== want.prio)
            report_mismatch("priority", out_priority_o, want.prio);
          if (entry_count_o !== want.count)
            report_mismatch("count", 32'(entry_count_o), 32'(want.count));
        end
        results_seen++;
      end
    end
  end

  // Result side: random stall bursts while idling is switched on.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sends one item; returns in the time step of the edge that accepted it.
  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_request(input logic [1:0] req, input logic [31:0] val,
                              input logic signed [31:0] prio, input bit pinned,
                              input result_t want);
    item_note_t note;
    note.pinned = pinned;
    note.want   = want;
    item_notes.push_back(note);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req;
    item_value_i    <= val;
    item_priority_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Priorities cluster on a few small values so ties and reordering are common,
  // with the extremes and full-range values mixed in.
  function automatic logic signed [31:0] pick_priority();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 6)) - 32'd3;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Stimulus: reset, the directed table, then bursts of random traffic that
  // lean towards filling or draining so both full and empty are reached often.
  initial begin
    dir_row_t     row;
    traffic_mix_e mix;
    logic [1:0]   req;
    int unsigned  burst_left;
    int unsigned  roll;
    bit           drained_once;
    drained_once = 1'b0;
    burst_left   = 0;
    mix          = MIX_EVEN;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    req_type_i      <= REQ_NONE;
    item_value_i    <= '0;
    item_priority_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[r]) begin
      row = DirectedRows[r];
      for (int unsigned k = 0; k < row.reps; k++)
        send_request(row.req, row.val + k, row.prio, row.pinned, row.want);
    end

    while (items_sent < TotalItems) begin
      if (burst_left == 0) begin
        // hold-off: stop sending until every result is back (never in the calm tail)
        if (items_sent < TotalItems - CalmTail &&
            ((!drained_once && items_sent >= 700) || $urandom_range(0, 9) == 0)) begin
          drained_once = 1'b1;
          in_valid_i <= 1'b0;
          while (results_seen != items_sent) @(posedge clk_i);
        end
        mix        = traffic_mix_e'($urandom_range(0, 2));
        burst_left = $urandom_range(8, 40);
        idle_on    = ($urandom_range(0, 3) != 0);
      end
      if (items_sent >= TotalItems - CalmTail) idle_on = 1'b0;

      roll = $urandom_range(0, 99);
      if (roll < 2)              req = REQ_CLR;
      else if (roll < 4)         req = REQ_NONE;
      else if (mix == MIX_FILL)  req = (roll < 86) ? REQ_ENQ : REQ_DEQ;
      else if (mix == MIX_DRAIN) req = (roll < 86) ? REQ_DEQ : REQ_ENQ;
      else                       req = (roll < 52) ? REQ_ENQ : REQ_DEQ;

      send_request(req, pick_value(), pick_priority(), 1'b0, '0);
      burst_left--;
    end

    in_valid_i <= 1'b0;
    while (results_seen != items_sent) @(posedge clk_i);
    // wait on to catch any stray result
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", pending_results.size(), 32'h0);

    if (mismatch_count == 0) begin
      $display("tb_sorted_priority_queue passed");
    end else begin
      $display("tb_sorted_priority_queue failed");
    end
    $finish;
  end

  // Watchdog: allow 5 ms.
  initial begin
    #(5_000_000);
    $display("tb_sorted_priority_queue failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_obuf.sv
rtl/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
